// ===== design/dwts_pkg.sv =====
// ----------------------------------------------------------------------------
// dwts_pkg: shared types, codes and helpers for the daily window timer switch
// Holds the action and item kind codes, register indexes, the window
// configuration bundle and the BCD to minute-of-day conversion.
// ----------------------------------------------------------------------------
package dwts_pkg;

	// field widths
	localparam int HOUR_W   = 6;
	localparam int MINUTE_W = 7;
	localparam int BCD_W    = 8;
	localparam int ACTION_W = 2;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 8;

	// minute of day, widest case is 165 * 60 + 165 for non-BCD digits
	localparam int MIN_W = 14;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ON   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_OFF  = 2'd2;

	// item kinds
	localparam logic KIND_CHECK = 1'b0;
	localparam logic KIND_PRESS = 1'b1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ALARM_ENABLE     = 3'd0;
	localparam logic [IDX_W-1:0] REG_START_HOUR       = 3'd1;
	localparam logic [IDX_W-1:0] REG_START_MINUTE     = 3'd2;
	localparam logic [IDX_W-1:0] REG_STOP_HOUR        = 3'd3;
	localparam logic [IDX_W-1:0] REG_STOP_MINUTE      = 3'd4;
	localparam logic [IDX_W-1:0] REG_ON_INSIDE_WINDOW = 3'd5;

	// register reset values
	localparam logic [BCD_W-1:0] BCD_RESET = 8'hff;

	typedef logic [MIN_W-1:0] minutes_t;

	// window settings as seen by the check logic
	typedef struct packed {
		logic     enable;
		logic     on_inside;
		minutes_t start_min;
		minutes_t stop_min;
	} window_cfg_t;

	// two nibbles weighted as tens and units, digits above nine kept as is
	function automatic logic [BCD_W-1:0] bcd_value(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] tens;
		logic [BCD_W-1:0] units;
		tens  = BCD_W'({4'd0, v[7:4]} * 8'd10);
		units = {4'd0, v[3:0]};
		return BCD_W'(tens + units);
	endfunction

	// hour and minute in BCD to minute of day
	function automatic minutes_t day_minutes(input logic [BCD_W-1:0] h,
		input logic [BCD_W-1:0] m);
		minutes_t hm;
		minutes_t mm;
		hm = MIN_W'({6'd0, bcd_value(h)} * 14'd60);
		mm = {6'd0, bcd_value(m)};
		return MIN_W'(hm + mm);
	endfunction

endpackage

// ===== design/dwts_cfg.sv =====
// ----------------------------------------------------------------------------
// dwts_cfg: configuration registers
// Holds the six window settings and presents start and stop as minutes of
// day together with the enable and drive level.
// ----------------------------------------------------------------------------
module dwts_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [dwts_pkg::IDX_W-1:0]  cfg_index,
	input  logic [dwts_pkg::DATA_W-1:0] cfg_data,
	output dwts_pkg::window_cfg_t     win_cfg
);
	import dwts_pkg::*;

	logic             alarm_enable_q;
	logic [BCD_W-1:0] start_hour_q;
	logic [BCD_W-1:0] start_minute_q;
	logic [BCD_W-1:0] stop_hour_q;
	logic [BCD_W-1:0] stop_minute_q;
	logic             on_inside_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_enable_q <= 1'b0;
			start_hour_q   <= BCD_RESET;
			start_minute_q <= BCD_RESET;
			stop_hour_q    <= BCD_RESET;
			stop_minute_q  <= BCD_RESET;
			on_inside_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALARM_ENABLE:     alarm_enable_q <= cfg_data[0];
				REG_START_HOUR:       start_hour_q   <= cfg_data;
				REG_START_MINUTE:     start_minute_q <= cfg_data;
				REG_STOP_HOUR:        stop_hour_q    <= cfg_data;
				REG_STOP_MINUTE:      stop_minute_q  <= cfg_data;
				REG_ON_INSIDE_WINDOW: on_inside_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// window bounds in minutes of day
	always_comb begin
		win_cfg.enable    = alarm_enable_q;
		win_cfg.on_inside = on_inside_q;
		win_cfg.start_min = day_minutes(start_hour_q, start_minute_q);
		win_cfg.stop_min  = day_minutes(stop_hour_q, stop_minute_q);
	end

endmodule

// ===== design/dwts_core.sv =====
// ----------------------------------------------------------------------------
// dwts_core: item path
// Input register, window test and edge detect, and the result register.
// The window flag and manual disable flag update as an item moves to the
// result register, so the next item sees them at once.
// ----------------------------------------------------------------------------
module dwts_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dwts_pkg::window_cfg_t         win_cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [dwts_pkg::HOUR_W-1:0]   hour_bcd,
	input  logic [dwts_pkg::MINUTE_W-1:0] minute_bcd,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dwts_pkg::ACTION_W-1:0] action
);
	import dwts_pkg::*;

	logic                valid_s1;
	logic                kind_s1;
	logic [HOUR_W-1:0]   hour_s1;
	logic [MINUTE_W-1:0] minute_s1;

	logic                out_valid_q;
	logic [ACTION_W-1:0] action_q;
	logic                in_window_q;
	logic                manual_dis_q;

	logic                advance;
	logic                accept;
	minutes_t            now_min;
	logic                win_hit;
	logic [ACTION_W-1:0] act_next;
	logic                in_window_next;
	logic                manual_dis_next;

	// handshake: result register frees when empty or taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			hour_s1   <= hour_bcd;
			minute_s1 <= minute_bcd;
		end
	end

	// window test, wraps past midnight when start is not before stop
	always_comb begin
		now_min = day_minutes({2'd0, hour_s1}, {1'b0, minute_s1});
		if (!win_cfg.enable) begin
			win_hit = 1'b0;
		end else if (win_cfg.start_min < win_cfg.stop_min) begin
			win_hit = (now_min >= win_cfg.start_min) && (now_min < win_cfg.stop_min);
		end else begin
			win_hit = (now_min >= win_cfg.start_min) || (now_min < win_cfg.stop_min);
		end
	end

	// entry and exit edges, manual press handling
	always_comb begin
		act_next        = ACT_NONE;
		in_window_next  = in_window_q;
		manual_dis_next = manual_dis_q;
		if (kind_s1 == KIND_PRESS) begin
			manual_dis_next = 1'b1;
		end else begin
			in_window_next = win_hit;
			if (win_hit) begin
				if (!in_window_q) begin
					manual_dis_next = 1'b0;
					act_next = win_cfg.on_inside ? ACT_ON : ACT_OFF;
				end
			end else if (!manual_dis_q && in_window_q) begin
				act_next = win_cfg.on_inside ? ACT_OFF : ACT_ON;
			end
		end
	end

	// result register and state flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			in_window_q  <= 1'b0;
			manual_dis_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				in_window_q  <= in_window_next;
				manual_dis_q <= manual_dis_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			action_q <= act_next;
		end
	end

	assign out_valid = out_valid_q;
	assign action    = action_q;

endmodule

// ===== design/daily_window_timer_switch.sv =====
// ----------------------------------------------------------------------------
// daily_window_timer_switch: daily on/off timer switch
// Checks BCD time samples against a configured daily window and reports
// entry and exit edges as drive-on or drive-off actions.
// ----------------------------------------------------------------------------
// Every item gives exactly one result, offered once the item moves from the
// input register to the result register, and a new item is taken in every
// cycle while results are being taken. The path
// is one input register, the BCD to minute conversion with the window
// compare, and one result register; the window and manual disable flags
// live beside the result register. Start and stop bounds are formed from
// the configuration registers, so write them only while no item is in
// flight. A manual press item always answers "no change".
module daily_window_timer_switch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dwts_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dwts_pkg::DATA_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [dwts_pkg::HOUR_W-1:0]   hour_bcd,
	input  logic [dwts_pkg::MINUTE_W-1:0] minute_bcd,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dwts_pkg::ACTION_W-1:0] action
);
	import dwts_pkg::*;

	window_cfg_t win_cfg;

	// configuration registers
	dwts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.win_cfg   (win_cfg)
	);

	// item path
	dwts_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.win_cfg    (win_cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.hour_bcd   (hour_bcd),
		.minute_bcd (minute_bcd),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.action     (action)
	);

endmodule

// ===== design/dwts_checker.sv =====
// ----------------------------------------------------------------------------
// dwts_checker: port-level checks for the daily window timer switch
// Watches the item channels and flags handshake and latency slips.
// ----------------------------------------------------------------------------
module dwts_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [dwts_pkg::ACTION_W-1:0] action
);
	import dwts_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(action))
		else $error("stalled result changed");

	// action is one of the three codes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (action == ACT_NONE || action == ACT_ON || action == ACT_OFF))
		else $error("action code out of range");

	// input only held back while a result waits and is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free result register");

	// a fresh result follows an item that was taken earlier
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching item");

endmodule

bind daily_window_timer_switch dwts_checker u_dwts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.action    (action)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: daily window timer switch
// Drives time check and manual press items through the block under several
// window settings and idle patterns. A scoreboard predicts each action from
// its own copy of the window registers and flags, and checks every result
// in order against it.
// ----------------------------------------------------------------------------

// predicted window state and the actions still to come out of the block
class switch_action_tracker;
	localparam int MAX_REPORTS = 10;

	logic       alarm_on;
	logic [7:0] start_hour;
	logic [7:0] start_minute;
	logic [7:0] stop_hour;
	logic [7:0] stop_minute;
	logic       drive_on_inside;
	logic       inside_now;
	logic       disarmed;
	logic [1:0] pending_actions[$];
	int         failures;

	function new();
		alarm_on        = 1'b0;
		start_hour      = dwts_pkg::BCD_RESET;
		start_minute    = dwts_pkg::BCD_RESET;
		stop_hour       = dwts_pkg::BCD_RESET;
		stop_minute     = dwts_pkg::BCD_RESET;
		drive_on_inside = 1'b1;
		inside_now      = 1'b0;
		disarmed        = 1'b0;
		failures        = 0;
	endfunction

	// tens and units nibbles, digits above nine weighted as they are
	function int digit_pair(logic [7:0] v);
		return int'(v[7:4]) * 10 + int'(v[3:0]);
	endfunction

	function int day_minute(logic [7:0] h, logic [7:0] m);
		return digit_pair(h) * 60 + digit_pair(m);
	endfunction

	function int window_start();
		return day_minute(start_hour, start_minute);
	endfunction

	function int window_stop();
		return day_minute(stop_hour, stop_minute);
	endfunction

	// register write, unknown indexes are dropped
	function void write_reg(logic [2:0] idx, logic [7:0] data);
		case (idx)
			dwts_pkg::REG_ALARM_ENABLE:     alarm_on = data[0];
			dwts_pkg::REG_START_HOUR:       start_hour = data;
			dwts_pkg::REG_START_MINUTE:     start_minute = data;
			dwts_pkg::REG_STOP_HOUR:        stop_hour = data;
			dwts_pkg::REG_STOP_MINUTE:      stop_minute = data;
			dwts_pkg::REG_ON_INSIDE_WINDOW: drive_on_inside = data[0];
			default: ;
		endcase
	endfunction

	// accepted item: update flags and queue the action it should produce
	function void note_item(logic k, logic [5:0] h, logic [6:0] m);
		logic [1:0] act;
		logic       hit;
		logic       was_inside;
		int         now_min;
		int         t0;
		int         t1;
		act = dwts_pkg::ACT_NONE;
		if (k == dwts_pkg::KIND_PRESS) begin
			disarmed = 1'b1;
		end else begin
			hit = 1'b0;
			was_inside = inside_now;
			if (alarm_on) begin
				now_min = day_minute({2'b00, h}, {1'b0, m});
				t0 = window_start();
				t1 = window_stop();
				if (t0 < t1)
					hit = (now_min >= t0) && (now_min < t1);
				else
					hit = (now_min >= t0) || (now_min < t1);
			end
			inside_now = hit;
			if (hit) begin
				if (!was_inside) begin
					disarmed = 1'b0;
					act = drive_on_inside ? dwts_pkg::ACT_ON : dwts_pkg::ACT_OFF;
				end
			end else if (!disarmed && was_inside) begin
				act = drive_on_inside ? dwts_pkg::ACT_OFF : dwts_pkg::ACT_ON;
			end
		end
		pending_actions.push_back(act);
	endfunction

	// compare one result with the oldest prediction
	function void check_action(logic [1:0] got);
		logic [1:0] want;
		if (pending_actions.size() == 0) begin
			failures++;
			if (failures <= MAX_REPORTS)
				$display("unexpected action %0d with no item pending", got);
		end else begin
			want = pending_actions.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("action mismatch: expected %0d got %0d", want, got);
			end
		end
	endfunction

	function int count_pending();
		return pending_actions.size();
	endfunction
endclass

module testbench;
	import dwts_pkg::*;

	localparam int         QUIET_LIMIT    = 4000;
	localparam int         RANDOM_PHASES  = 8;
	localparam int         PHASE_ITEMS    = 150;
	localparam logic [2:0] REG_OUT_OF_MAP = 3'd7;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [DATA_W-1:0]   cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                kind = KIND_CHECK;
	logic [HOUR_W-1:0]   hour_bcd = '0;
	logic [MINUTE_W-1:0] minute_bcd = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [ACTION_W-1:0] action;

	switch_action_tracker tracker = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	daily_window_timer_switch dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.hour_bcd   (hour_bcd),
		.minute_bcd (minute_bcd),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.action     (action)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: check taken results, draw the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_action(action);
		out_stall <= arst_n && ($urandom_range(0, 99) < stall_pct);
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	// decimal 0..99 to two BCD nibbles
	function automatic logic [7:0] bcd2(input int n);
		return {4'(n / 10), 4'(n % 10)};
	endfunction

	// offer one item after a random gap and wait until it is taken
	task automatic send_item(input logic k, input logic [7:0] h, input logic [7:0] m);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		hour_bcd   <= h[5:0];
		minute_bcd <= m[6:0];
		do
			@(posedge clk);
		while (in_stall);
		tracker.note_item(k, h[5:0], m[6:0]);
	endtask

	// stop offering items until every predicted action has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (tracker.count_pending() != 0)
			@(posedge clk);
	endtask

	// one register write per cycle, block idle
	task automatic write_regs(input logic [2:0] idx[], input logic [7:0] data[]);
		drain_results();
		foreach (idx[i]) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= data[i];
			@(posedge clk);
			tracker.write_reg(idx[i], data[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// full window setting, junk above bit zero of the one-bit registers
	task automatic set_window(input logic en, input logic [7:0] sh, input logic [7:0] sm,
		input logic [7:0] eh, input logic [7:0] em, input logic oi);
		logic [2:0] idx[];
		logic [7:0] data[];
		idx  = '{REG_ALARM_ENABLE, REG_START_HOUR, REG_START_MINUTE,
			REG_STOP_HOUR, REG_STOP_MINUTE, REG_ON_INSIDE_WINDOW};
		data = '{{7'($urandom), en}, sh, sm, eh, em, {7'($urandom), oi}};
		write_regs(idx, data);
	endtask

	// random window: mostly proper BCD times, some equal bounds, some raw bytes
	task automatic random_window();
		int r;
		int t0;
		int t1;
		r  = $urandom_range(0, 9);
		t0 = $urandom_range(0, 1439);
		t1 = (r == 1) ? t0 : $urandom_range(0, 1439);
		if (r == 0)
			set_window($urandom_range(0, 9) != 0, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		else
			set_window($urandom_range(0, 9) != 0, bcd2(t0 / 60), bcd2(t0 % 60),
				bcd2(t1 / 60), bcd2(t1 % 60), 1'($urandom_range(0, 1)));
	endtask

	// random presses and checks, part of them close to a window bound so edges are frequent
	task automatic run_random(input int count);
		int r;
		int base;
		int t;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_item(KIND_PRESS, 8'($urandom_range(0, 35)), 8'($urandom_range(0, 89)));
			end else if (r < 20) begin
				send_item(KIND_CHECK, 8'($urandom_range(0, 35)), 8'($urandom_range(0, 89)));
			end else begin
				base = $urandom_range(0, 1) ? tracker.window_start() : tracker.window_stop();
				if (r < 65 && base < 1440)
					t = (base + 1440 + $urandom_range(0, 6) - 3) % 1440;
				else
					t = $urandom_range(0, 1439);
				send_item(KIND_CHECK, bcd2(t / 60), bcd2(t % 60));
			end
		end
	endtask

	// main sequence
	initial begin
		logic [2:0] one_idx[];
		logic [7:0] one_data[];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: checking off, field extremes, press with extreme fields
		send_item(KIND_CHECK, 8'h00, 8'h00);
		send_item(KIND_CHECK, 8'h23, 8'h59);
		send_item(KIND_PRESS, 8'h23, 8'h59);

		// plain window, press inside it blocks the exit action
		set_window(1'b1, 8'h08, 8'h30, 8'h17, 8'h45, 1'b1);
		send_item(KIND_CHECK, 8'h08, 8'h29);
		send_item(KIND_CHECK, 8'h08, 8'h30);
		send_item(KIND_PRESS, 8'h00, 8'h00);
		send_item(KIND_CHECK, 8'h17, 8'h45);
		send_item(KIND_CHECK, 8'h12, 8'h00);
		send_item(KIND_CHECK, 8'h17, 8'h44);
		send_item(KIND_CHECK, 8'h17, 8'h45);

		// window past midnight with inverted drive
		set_window(1'b1, 8'h22, 8'h00, 8'h06, 8'h00, 1'b0);
		send_item(KIND_CHECK, 8'h23, 8'h59);
		send_item(KIND_CHECK, 8'h05, 8'h59);
		send_item(KIND_CHECK, 8'h06, 8'h00);

		// equal bounds cover the whole day, non-BCD digits included
		set_window(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		send_item(KIND_CHECK, 8'h12, 8'h00);
		send_item(KIND_CHECK, 8'h1f, 8'h3f);

		// checking switched off while inside gives an exit
		one_idx  = '{REG_ALARM_ENABLE};
		one_data = '{8'h00};
		write_regs(one_idx, one_data);
		send_item(KIND_CHECK, 8'h12, 8'h00);

		// reset-valued bounds with checking on, then a write to an unused index
		set_window(1'b1, BCD_RESET, BCD_RESET, BCD_RESET, BCD_RESET, 1'b0);
		send_item(KIND_CHECK, 8'h00, 8'h00);
		one_idx  = '{REG_OUT_OF_MAP};
		one_data = '{8'h00};
		write_regs(one_idx, one_data);
		send_item(KIND_CHECK, 8'h23, 8'h59);
		send_item(KIND_CHECK, 8'h10, 8'h00);

		// random phases with different idle patterns
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_window();
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 88; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 88; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			run_random(PHASE_ITEMS / 2);
			drain_results();
			run_random(PHASE_ITEMS / 2);
		end

		// wait out the last results, then report
		drain_results();
		repeat (4) @(posedge clk);
		if (tracker.count_pending() != 0)
			$display("%0d predicted actions never came out", tracker.count_pending());
		if (tracker.failures == 0 && tracker.count_pending() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
